[hdl/task_watchdog_supervisor_assert.svh]
// ----------------------------------------------------------------------------
// Task watchdog supervisor assertion macros
// Shared assertion forms for the checker attached to the supervisor.
// ----------------------------------------------------------------------------
`ifndef TASK_WATCHDOG_SUPERVISOR_ASSERT_SVH
`define TASK_WATCHDOG_SUPERVISOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TWD_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/twd_pkg.sv]
// ----------------------------------------------------------------------------
// twd_pkg
// Types, codes and helpers shared by the task watchdog supervisor.
// ----------------------------------------------------------------------------
package twd_pkg;

	localparam int          TWD_MAX_ENTRIES     = 8;
	localparam logic [31:0] TWD_HEAP_WARN_RESET = 32'd32768;

	localparam logic [3:0] ERR_BUS_OFF   = 4'd1;
	localparam logic [3:0] ERR_LINK_DOWN = 4'd4;

	typedef enum logic [2:0] {
		CMD_REGISTER     = 3'd0,
		CMD_CHECKIN      = 3'd1,
		CMD_TICK         = 3'd2,
		CMD_REQUEST      = 3'd3,
		CMD_REPORT_ERROR = 3'd4
	} twd_cmd_t;

	typedef enum logic [2:0] {
		MODE_INIT      = 3'd0,
		MODE_CONN_CAN  = 3'd1,
		MODE_CONN_COMM = 3'd2,
		MODE_RUNNING   = 3'd3,
		MODE_ERROR     = 3'd4,
		MODE_FATAL     = 3'd5
	} twd_mode_t;

	typedef enum logic [1:0] {
		KIND_STATUS     = 2'd0,
		KIND_HEAP_LOW   = 2'd1,
		KIND_TASK_STUCK = 2'd2
	} twd_kind_t;

	typedef enum logic [1:0] {
		STS_OK             = 2'd0,
		STS_BAD_TRANSITION = 2'd1,
		STS_BAD_ENTRY      = 2'd2,
		STS_NO_MATCH       = 2'd3
	} twd_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CHK_RD,
		S_CHK_CMP,
		S_CHK_TEST,
		S_TICK_FLOOR,
		S_TICK_HEAP,
		S_SCAN_RD,
		S_SCAN_SUB,
		S_SCAN_CMP,
		S_SCAN_TEST,
		S_TICK_DONE,
		S_EMIT
	} twd_state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] task_id;
		logic [31:0] timeout_ms;
		logic [31:0] now_ms;
		logic [31:0] heap_free_bytes;
		logic [31:0] heap_min_bytes;
		logic [2:0]  wanted_state;
		logic [3:0]  error_code;
	} twd_item_t;

	typedef struct packed {
		twd_kind_t   kind;
		twd_status_t status;
		logic [2:0]  task_index;
		logic [31:0] elapsed_ms;
		twd_mode_t   mode;
		logic [31:0] errors_seen;
		logic [31:0] mode_changes;
		logic [31:0] up_seconds;
		logic [31:0] lowest_heap;
		logic        start_bus;
		logic        bus_recovery;
		logic        last;
	} twd_result_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] timeout;
		logic [31:0] checkin;
	} twd_entry_t;

	typedef struct packed {
		logic        en;
		logic [31:0] a;
		logic [31:0] b;
	} twd_alu_req_t;

	typedef struct packed {
		logic [31:0] diff;
		logic        borrow;
		logic        zero;
	} twd_alu_rsp_t;

	localparam logic [7:0] ALLOWED_NEXT [8] = '{
		8'h02, 8'h14, 8'h18, 8'h16, 8'h22, 8'h00, 8'h00, 8'h00
	};

	function automatic logic mode_allowed(twd_mode_t cur, logic [2:0] wanted);
		logic [7:0] mask;
		mask = ALLOWED_NEXT[cur];
		return (wanted <= 3'(MODE_FATAL)) && mask[wanted];
	endfunction

endpackage

[hdl/twd_ifs.sv]
// ----------------------------------------------------------------------------
// twd channel interfaces
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
interface twd_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] task_id;
	logic [31:0] timeout_ms;
	logic [31:0] now_ms;
	logic [31:0] heap_free_bytes;
	logic [31:0] heap_min_bytes;
	logic [2:0]  wanted_state;
	logic [3:0]  error_code;

	modport source (
		output valid, command, task_id, timeout_ms, now_ms, heap_free_bytes,
		       heap_min_bytes, wanted_state, error_code,
		input  ready
	);
	modport sink (
		input  valid, command, task_id, timeout_ms, now_ms, heap_free_bytes,
		       heap_min_bytes, wanted_state, error_code,
		output ready
	);
endinterface

interface twd_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [2:0]  task_index;
	logic [31:0] elapsed_ms;
	logic [2:0]  mode;
	logic [31:0] errors_seen;
	logic [31:0] mode_changes;
	logic [31:0] up_seconds;
	logic [31:0] lowest_heap;
	logic        start_bus;
	logic        bus_recovery;
	logic        last;

	modport source (
		output valid, kind, status, task_index, elapsed_ms, mode, errors_seen,
		       mode_changes, up_seconds, lowest_heap, start_bus, bus_recovery, last,
		input  ready
	);
	modport sink (
		input  valid, kind, status, task_index, elapsed_ms, mode, errors_seen,
		       mode_changes, up_seconds, lowest_heap, start_bus, bus_recovery, last,
		output ready
	);
endinterface

interface twd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[hdl/task_watchdog_supervisor.sv]
// ----------------------------------------------------------------------------
// task_watchdog_supervisor
// Task watchdog table with system mode machine, error and uptime statistics.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  cmd     | in  | command, task_id, timeout_ms, now_ms, ... | valid/ready
//  rsp     | out | kind, status, task_index, ... , last      | valid/ready
//  cfg     | in  | heap_warn_level write data                | valid/ready
//
//  Register, request state and report error: decoded, then sent from emit.
//  Checkin: read, compare and test per slot, one more read when no slot matches.
//  Tick: read, subtract, compare and test per watched slot, read and subtract per
//  unwatched one, paced by the table read and two shared-subtractor passes.
//  cmd.ready is high only in idle, entered as the closing word is loaded.
//  A stalled rsp holds its word in the output register; the sequencer waits.
//  Reset clears mode, counters and the fill count; table entries are not reset.
module task_watchdog_supervisor import twd_pkg::*; #(
	parameter int MAX_ENTRIES = TWD_MAX_ENTRIES
) (
	input logic    clk,
	input logic    arst_n,
	twd_cfg_if.sink  cfg,
	twd_cmd_if.sink  cmd,
	twd_rsp_if.source rsp
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [31:0]      heap_warn_q;
	twd_item_t        item;
	logic             slot_free;
	logic             emit_valid;
	twd_result_t      emit_res;
	twd_result_t      out_q;
	logic             out_valid_q;
	twd_alu_req_t     alu_req;
	twd_alu_rsp_t     alu_rsp;
	logic             tbl_wr_all;
	logic             tbl_wr_ck;
	logic [IDX_W-1:0] tbl_wr_addr;
	twd_entry_t       tbl_wr_entry;
	logic [IDX_W-1:0] tbl_rd_addr;
	twd_entry_t       tbl_rd_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_warn_q <= TWD_HEAP_WARN_RESET;
		end else if (cfg.valid) begin
			heap_warn_q <= cfg.data;
		end
	end

	assign item = '{command: cmd.command, task_id: cmd.task_id,
	                timeout_ms: cmd.timeout_ms, now_ms: cmd.now_ms,
	                heap_free_bytes: cmd.heap_free_bytes,
	                heap_min_bytes: cmd.heap_min_bytes,
	                wanted_state: cmd.wanted_state, error_code: cmd.error_code};

	twd_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cmd.valid),
		.in_ready     (cmd.ready),
		.in_item      (item),
		.heap_warn    (heap_warn_q),
		.slot_free    (slot_free),
		.emit_valid   (emit_valid),
		.emit_res     (emit_res),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp),
		.tbl_wr_all   (tbl_wr_all),
		.tbl_wr_ck    (tbl_wr_ck),
		.tbl_wr_addr  (tbl_wr_addr),
		.tbl_wr_entry (tbl_wr_entry),
		.tbl_rd_addr  (tbl_rd_addr),
		.tbl_rd_entry (tbl_rd_entry)
	);

	twd_alu u_alu (
		.clk (clk),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	twd_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
		.clk      (clk),
		.wr_all   (tbl_wr_all),
		.wr_ck    (tbl_wr_ck),
		.wr_addr  (tbl_wr_addr),
		.wr_entry (tbl_wr_entry),
		.rd_addr  (tbl_rd_addr),
		.rd_entry (tbl_rd_entry)
	);

	// output word register: load when empty or being drained
	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit_valid) begin
			out_q <= emit_res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_q.kind;
	assign rsp.status       = out_q.status;
	assign rsp.task_index   = out_q.task_index;
	assign rsp.elapsed_ms   = out_q.elapsed_ms;
	assign rsp.mode         = out_q.mode;
	assign rsp.errors_seen  = out_q.errors_seen;
	assign rsp.mode_changes = out_q.mode_changes;
	assign rsp.up_seconds   = out_q.up_seconds;
	assign rsp.lowest_heap  = out_q.lowest_heap;
	assign rsp.start_bus    = out_q.start_bus;
	assign rsp.bus_recovery = out_q.bus_recovery;
	assign rsp.last         = out_q.last;

endmodule

[hdl/twd_alu.sv]
// ----------------------------------------------------------------------------
// twd_alu
// Shared 32-bit subtract/compare unit with a registered result.
// ----------------------------------------------------------------------------
module twd_alu import twd_pkg::*; (
	input  logic         clk,
	input  twd_alu_req_t req,
	output twd_alu_rsp_t rsp
);

	logic [32:0] sum;
	logic [31:0] diff_q;
	logic        borrow_q;

	assign sum = {1'b0, req.a} - {1'b0, req.b};

	always_ff @(posedge clk) begin
		if (req.en) begin
			diff_q   <= sum[31:0];
			borrow_q <= sum[32];
		end
	end

	assign rsp.diff   = diff_q;
	assign rsp.borrow = borrow_q;
	assign rsp.zero   = (diff_q == 32'd0);

endmodule

[hdl/twd_table.sv]
// ----------------------------------------------------------------------------
// twd_table
// Task table memory: id, timeout and last check-in per slot, registered read.
// ----------------------------------------------------------------------------
module twd_table import twd_pkg::*; #(
	parameter  int MAX_ENTRIES = TWD_MAX_ENTRIES,
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             wr_all,
	input  logic             wr_ck,
	input  logic [IDX_W-1:0] wr_addr,
	input  twd_entry_t       wr_entry,
	input  logic [IDX_W-1:0] rd_addr,
	output twd_entry_t       rd_entry
);

	logic [31:0] mem_id      [MAX_ENTRIES];
	logic [31:0] mem_timeout [MAX_ENTRIES];
	logic [31:0] mem_checkin [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_all) begin
			mem_id[wr_addr]      <= wr_entry.id;
			mem_timeout[wr_addr] <= wr_entry.timeout;
		end
		if (wr_all || wr_ck) begin
			mem_checkin[wr_addr] <= wr_entry.checkin;
		end
	end

	always_ff @(posedge clk) begin
		rd_entry.id      <= mem_id[rd_addr];
		rd_entry.timeout <= mem_timeout[rd_addr];
		rd_entry.checkin <= mem_checkin[rd_addr];
	end

endmodule

[hdl/twd_ctrl.sv]
// ----------------------------------------------------------------------------
// twd_ctrl
// Sequencer: mode machine, counters and the table scans over the shared unit.
// ----------------------------------------------------------------------------
module twd_ctrl import twd_pkg::*; #(
	parameter  int MAX_ENTRIES = TWD_MAX_ENTRIES,
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  twd_item_t        in_item,
	input  logic [31:0]      heap_warn,
	input  logic             slot_free,
	output logic             emit_valid,
	output twd_result_t      emit_res,
	output twd_alu_req_t     alu_req,
	input  twd_alu_rsp_t     alu_rsp,
	output logic             tbl_wr_all,
	output logic             tbl_wr_ck,
	output logic [IDX_W-1:0] tbl_wr_addr,
	output twd_entry_t       tbl_wr_entry,
	output logic [IDX_W-1:0] tbl_rd_addr,
	input  twd_entry_t       tbl_rd_entry
);

	twd_state_t  state_q, state_d;
	twd_item_t   item_q;
	twd_mode_t   mode_q, mode_d;
	logic [31:0] err_q, err_d;
	logic [31:0] chg_q, chg_d;
	logic [31:0] up_q, up_d;
	logic [31:0] floor_q, floor_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [31:0] elapsed_q, elapsed_d;
	twd_status_t sts_q, sts_d;
	logic [IDX_W-1:0] ridx_q, ridx_d;
	logic        sb_q, sb_d;
	logic        rc_q, rc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INIT;
			err_q     <= '0;
			chg_q     <= '0;
			up_q      <= '0;
			floor_q   <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			elapsed_q <= '0;
			sts_q     <= STS_OK;
			ridx_q    <= '0;
			sb_q      <= 1'b0;
			rc_q      <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			err_q     <= err_d;
			chg_q     <= chg_d;
			up_q      <= up_d;
			floor_q   <= floor_d;
			cnt_q     <= cnt_d;
			idx_q     <= idx_d;
			elapsed_q <= elapsed_d;
			sts_q     <= sts_d;
			ridx_q    <= ridx_d;
			sb_q      <= sb_d;
			rc_q      <= rc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		err_d     = err_q;
		chg_d     = chg_q;
		up_d      = up_q;
		floor_d   = floor_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		elapsed_d = elapsed_q;
		sts_d     = sts_q;
		ridx_d    = ridx_q;
		sb_d      = sb_q;
		rc_d      = rc_q;

		in_ready     = 1'b0;
		alu_req      = '{en: 1'b0, a: 32'd0, b: 32'd0};
		tbl_wr_all   = 1'b0;
		tbl_wr_ck    = 1'b0;
		tbl_wr_addr  = IDX_W'(idx_q);
		tbl_rd_addr  = IDX_W'(idx_q);
		tbl_wr_entry = '{id: item_q.task_id, timeout: item_q.timeout_ms,
		                 checkin: item_q.now_ms};

		// closing status word unless an alarm overrides it
		emit_valid = 1'b0;
		emit_res   = '{kind: KIND_STATUS, status: sts_q, task_index: 3'(ridx_q),
		               elapsed_ms: 32'd0, mode: mode_q, errors_seen: err_q,
		               mode_changes: chg_q, up_seconds: up_q, lowest_heap: floor_q,
		               start_bus: sb_q, bus_recovery: rc_q, last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				sts_d   = STS_OK;
				ridx_d  = '0;
				sb_d    = 1'b0;
				rc_d    = 1'b0;
				idx_d   = '0;
				state_d = S_EMIT;
				unique case (item_q.command)
					CMD_REGISTER: begin
						if (item_q.task_id == 32'd0 || cnt_q >= CNT_W'(MAX_ENTRIES)) begin
							sts_d = STS_BAD_ENTRY;
						end else begin
							tbl_wr_all  = 1'b1;
							tbl_wr_addr = IDX_W'(cnt_q);
							ridx_d      = IDX_W'(cnt_q);
							cnt_d       = cnt_q + CNT_W'(1);
						end
					end
					CMD_CHECKIN: begin
						if (item_q.task_id == 32'd0) begin
							sts_d = STS_NO_MATCH;
						end else begin
							state_d = S_CHK_RD;
						end
					end
					CMD_TICK: begin
						up_d    = up_q + 32'd1;
						alu_req = '{en: 1'b1, a: item_q.heap_min_bytes, b: floor_q};
						state_d = S_TICK_FLOOR;
					end
					CMD_REQUEST: begin
						if (mode_allowed(mode_q, item_q.wanted_state)) begin
							mode_d = twd_mode_t'(item_q.wanted_state);
							chg_d  = chg_q + 32'd1;
							sb_d   = (item_q.wanted_state == 3'(MODE_CONN_CAN));
						end else begin
							sts_d = STS_BAD_TRANSITION;
						end
					end
					CMD_REPORT_ERROR: begin
						err_d = err_q + 32'd1;
						// link loss drops a running system back to connecting-comm
						if (item_q.error_code == ERR_LINK_DOWN && mode_q == MODE_RUNNING) begin
							mode_d = MODE_CONN_COMM;
							chg_d  = chg_q + 32'd1;
						end
						rc_d = (item_q.error_code == ERR_BUS_OFF);
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_CHK_RD: begin
				if (idx_q >= cnt_q) begin
					sts_d   = STS_NO_MATCH;
					state_d = S_EMIT;
				end else begin
					state_d = S_CHK_CMP;
				end
			end
			S_CHK_CMP: begin
				alu_req = '{en: 1'b1, a: tbl_rd_entry.id, b: item_q.task_id};
				state_d = S_CHK_TEST;
			end
			S_CHK_TEST: begin
				if (alu_rsp.zero) begin
					tbl_wr_ck = 1'b1;
					state_d   = S_EMIT;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_CHK_RD;
				end
			end
			S_TICK_FLOOR: begin
				if (alu_rsp.borrow || floor_q == 32'd0) begin
					floor_d = item_q.heap_min_bytes;
				end
				alu_req = '{en: 1'b1, a: item_q.heap_free_bytes, b: heap_warn};
				state_d = S_TICK_HEAP;
			end
			S_TICK_HEAP: begin
				if (alu_rsp.borrow) begin
					emit_valid           = 1'b1;
					emit_res.kind        = KIND_HEAP_LOW;
					emit_res.status      = STS_OK;
					emit_res.task_index  = 3'd0;
					emit_res.errors_seen = err_q + 32'd1;
					emit_res.start_bus   = 1'b0;
					emit_res.bus_recovery = 1'b0;
					emit_res.last        = 1'b0;
					if (slot_free) begin
						err_d   = err_q + 32'd1;
						state_d = S_SCAN_RD;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = (idx_q >= cnt_q) ? S_TICK_DONE : S_SCAN_SUB;
			end
			S_SCAN_SUB: begin
				// a zero timeout is never overdue
				if (tbl_rd_entry.timeout == 32'd0) begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_SCAN_RD;
				end else begin
					alu_req = '{en: 1'b1, a: item_q.now_ms, b: tbl_rd_entry.checkin};
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				elapsed_d = alu_rsp.diff;
				alu_req   = '{en: 1'b1, a: tbl_rd_entry.timeout, b: alu_rsp.diff};
				state_d   = S_SCAN_TEST;
			end
			S_SCAN_TEST: begin
				if (alu_rsp.borrow) begin
					emit_valid           = 1'b1;
					emit_res.kind        = KIND_TASK_STUCK;
					emit_res.status      = STS_OK;
					emit_res.task_index  = 3'(idx_q);
					emit_res.elapsed_ms  = elapsed_q;
					emit_res.errors_seen = err_q + 32'd1;
					emit_res.start_bus   = 1'b0;
					emit_res.bus_recovery = 1'b0;
					emit_res.last        = 1'b0;
					if (slot_free) begin
						err_d   = err_q + 32'd1;
						idx_d   = idx_q + CNT_W'(1);
						state_d = S_SCAN_RD;
					end
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_SCAN_RD;
				end
			end
			S_TICK_DONE: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				emit_valid = 1'b1;
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/twd_checker.sv]
// ----------------------------------------------------------------------------
// twd_checker
// Port-level checks on the supervisor, attached by bind.
// ----------------------------------------------------------------------------
`include "task_watchdog_supervisor_assert.svh"

module twd_checker import twd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic [1:0]  rsp_status,
	input logic [2:0]  rsp_mode,
	input logic [31:0] rsp_errors,
	input logic        rsp_start_bus,
	input logic        rsp_last
);

	// one word at a time: a taken command closes the door for the next cycle
	`TWD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "command accepted while busy")

	`TWD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_errors) && $stable(rsp_last), "stalled result changed")

	`TWD_ASSERT_HOLD(a_alarm_not_last, clk, arst_n, rsp_valid && rsp_kind != KIND_STATUS, rsp_status == STS_OK && !rsp_last, "alarm word closed a run or carried a status")

	`TWD_ASSERT_HOLD(a_start_bus_mode, clk, arst_n, rsp_valid && rsp_start_bus, rsp_mode == MODE_CONN_CAN, "bus start outside connecting-can")

	`TWD_ASSERT_HOLD(a_mode_range, clk, arst_n, rsp_valid, rsp_mode <= MODE_FATAL, "mode out of range")

endmodule

bind task_watchdog_supervisor twd_checker u_twd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_kind      (rsp.kind),
	.rsp_status    (rsp.status),
	.rsp_mode      (rsp.mode),
	.rsp_errors    (rsp.errors_seen),
	.rsp_start_bus (rsp.start_bus),
	.rsp_last      (rsp.last)
);
